>>> sv/trf_pkg.sv
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants for the temperature report filter
// Holds the action codes, register indexes, reset values and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

  // Default channel count for the per-channel state
  localparam int CHANNELS_DEF = 32;

  // Field widths
  localparam int CHAN_W = 5;
  localparam int RAW_W  = 16;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 8;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FAILURE_LIMIT = 1'b0,
    CFG_SKIP_LIMIT    = 1'b1
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [CNT_W-1:0] FAILURE_LIMIT_RST = 8'd3;
  localparam logic [CNT_W-1:0] SKIP_LIMIT_RST    = 8'd5;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_VALUE   = 2'd1,
    ACT_UNKNOWN = 2'd2
  } act_t;

  // Readings closer than this to the stored value count as small changes
  localparam logic [RAW_W:0] CLOSE_BAND = 17'd10;

  // Value sent with an unknown report
  localparam logic [RAW_W-1:0] UNKNOWN_CODE = 16'h8000;

  // Counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

endpackage : trf_pkg

`default_nettype wire

>>> sv/temperature_report_filter_core.sv
// ----------------------------------------------------------------------------
// temperature_report_filter_core: per-channel temperature report filter
// Each input word is held in the input register, then in the result register.
// Throughput: one word per cycle while out_tready is high; per-channel counters
// and last value are read, updated and written in the single compute stage.
// Reset (rst_n low, synchronous): pipeline empties, all per-channel state
// clears to zero, failure_limit returns to 3 and skip_limit to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_report_filter_core
  import trf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [4:0] channel, [20:5] raw_reading
  input  wire logic [0:0]  in_tuser,   // [0] disconnected

  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [4:0] channel_out, [20:5] report_value
  output logic [1:0]       out_tuser,  // [1:0] action

  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  // Only channel numbers that fit the channel field ever reach the state
  localparam int DEPTH = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);

  // Configuration registers
  logic [CNT_W-1:0] failure_limit_r;
  logic [CNT_W-1:0] skip_limit_r;

  // Per-channel state
  logic signed [RAW_W-1:0] last_r    [DEPTH];
  logic [CNT_W-1:0]        fail_cnt_r[DEPTH];
  logic [CNT_W-1:0]        skip_cnt_r[DEPTH];

  // Input stage
  logic              s1_valid_r;
  logic [CHAN_W-1:0] s1_chan_r;
  logic [RAW_W-1:0]  s1_raw_r;
  logic              s1_disc_r;

  // Output stage
  logic              out_valid_r;
  logic [CHAN_W-1:0] out_chan_r;
  act_t              out_act_r;
  logic [RAW_W-1:0]  out_val_r;

  // Compute-stage signals
  logic                    adv;
  logic                    s1_fire;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic                    fail;
  logic signed [20:0]      prod;
  logic signed [20:0]      biased;
  logic signed [RAW_W-1:0] centi;
  logic signed [RAW_W:0]   diff;
  logic [RAW_W:0]          diff_abs;
  logic                    close;
  logic [CNT_W-1:0]        fail_inc;
  logic [CNT_W-1:0]        skip_inc;
  logic [CNT_W-1:0]        fail_cnt_nxt;
  logic [CNT_W-1:0]        skip_cnt_nxt;
  logic signed [RAW_W-1:0] last_nxt;
  act_t                    act_nxt;
  logic [RAW_W-1:0]        val_nxt;

  // Handshake: the output register frees the compute stage when taken
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign s1_fire   = s1_valid_r && adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_val_r, out_chan_r};
  assign out_tuser  = out_act_r;

  // Channel lookup
  assign in_range = {4'b0000, s1_chan_r} < CH_LIMIT;
  assign idx      = s1_chan_r[IDX_W-1:0];
  assign fail     = s1_disc_r || (s1_raw_r == '0);

  // raw * 25 / 32, truncated toward zero
  assign prod   = $signed({{5{s1_raw_r[RAW_W-1]}}, s1_raw_r}) * 21'sd25;
  assign biased = prod + (prod[20] ? 21'sd31 : 21'sd0);
  assign centi  = biased[20:5];

  // Distance from the last reported value
  assign diff     = $signed({last_r[idx][RAW_W-1], last_r[idx]})
                  - $signed({centi[RAW_W-1], centi});
  assign diff_abs = diff[RAW_W] ? 17'(-diff) : 17'(diff);
  assign close    = diff_abs < CLOSE_BAND;

  assign fail_inc = (fail_cnt_r[idx] == CNT_MAX) ? CNT_MAX : fail_cnt_r[idx] + 8'd1;
  assign skip_inc = skip_cnt_r[idx] + 8'd1;

  // Decision and state update
  always_comb begin
    fail_cnt_nxt = fail_cnt_r[idx];
    skip_cnt_nxt = skip_cnt_r[idx];
    last_nxt     = last_r[idx];
    act_nxt      = ACT_NONE;
    val_nxt      = '0;
    if (!in_range) begin
      act_nxt = ACT_NONE;
    end else if (fail) begin
      fail_cnt_nxt = fail_inc;
      if (fail_inc > failure_limit_r) begin
        act_nxt = ACT_UNKNOWN;
        val_nxt = UNKNOWN_CODE;
      end
    end else if (close && !(skip_inc > skip_limit_r)) begin
      // small change, still suppressed
      skip_cnt_nxt = skip_inc;
    end else begin
      // large change, or small change forced out
      skip_cnt_nxt = '0;
      last_nxt     = centi;
      act_nxt      = ACT_VALUE;
      val_nxt      = centi;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failure_limit_r <= FAILURE_LIMIT_RST;
      skip_limit_r    <= SKIP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FAILURE_LIMIT: failure_limit_r <= cfg_wdata;
        CFG_SKIP_LIMIT:    skip_limit_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-channel state write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        last_r[i]     <= '0;
        fail_cnt_r[i] <= '0;
        skip_cnt_r[i] <= '0;
      end
    end else if (s1_fire && in_range) begin
      last_r[idx]     <= last_nxt;
      fail_cnt_r[idx] <= fail_cnt_nxt;
      skip_cnt_r[idx] <= skip_cnt_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_chan_r <= in_tdata[4:0];
      s1_raw_r  <= in_tdata[20:5];
      s1_disc_r <= in_tuser[0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_chan_r <= s1_chan_r;
      out_act_r  <= act_nxt;
      out_val_r  <= val_nxt;
    end
  end

  // Unknown reports always carry the unknown code
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ACT_UNKNOWN) |-> out_tdata[20:5] == UNKNOWN_CODE)
    else $error("unknown report without unknown code");

  // A stalled result with a pending item must hold off the input
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline is full");

  // A value report leaves the channel's stored value equal to it
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && in_range && act_nxt == ACT_VALUE)
      |=> last_r[$past(idx)] == $signed($past(val_nxt)))
    else $error("stored value differs from reported value");

  // No report is issued for a channel outside the configured range
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !in_range) |=> out_act_r == ACT_NONE && out_val_r == '0)
    else $error("report for channel out of range");

endmodule : temperature_report_filter_core

`default_nettype wire
